### rtl/vector_refraction_direction_assert.svh
// assertion macros used by the port-level checker
`ifndef VECTOR_REFRACTION_DIRECTION_ASSERT_SVH
`define VECTOR_REFRACTION_DIRECTION_ASSERT_SVH

// property that must hold at every sampled edge out of reset
`define VRD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vrd check failed");

// condition in one cycle that forces a consequence in the next
`define VRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrd check failed");

`endif

### rtl/vrd_pkg.sv
// shared constants for the refraction pipeline
package vrd_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 18;
    localparam int SQRT_BITS = 29;
    localparam int RAD_W     = 60;
    localparam int P_W       = 30;
    localparam int NSTG      = 8 + SQRT_BITS + 2;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

endpackage

### rtl/vector_refraction_direction.sv
// snell vector refraction, fully pipelined
// One ray enters per cycle unless the output stalls; the pipeline depth
// is set by the square root, which resolves one root bit per stage
// over 29 stages, plus eight stages ahead of it (dot product, cosine cap,
// scaling by eta, rounding, squared length) and two after it (scaling the
// normal, rounding and saturation). When the output is stalled the whole
// pipeline holds; ready is low only while a finished result waits.
module vector_refraction_direction (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [vrd_pkg::IN_W-1:0]       dir_x,
    input  logic signed [vrd_pkg::IN_W-1:0]       dir_y,
    input  logic signed [vrd_pkg::IN_W-1:0]       dir_z,
    input  logic signed [vrd_pkg::IN_W-1:0]       norm_x,
    input  logic signed [vrd_pkg::IN_W-1:0]       norm_y,
    input  logic signed [vrd_pkg::IN_W-1:0]       norm_z,
    input  logic        [vrd_pkg::IN_W-1:0]       eta_ratio,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [vrd_pkg::OUT_W-1:0]      out_x,
    output logic signed [vrd_pkg::OUT_W-1:0]      out_y,
    output logic signed [vrd_pkg::OUT_W-1:0]      out_z,
    output logic                                  saturated
);
    import vrd_pkg::*;

    logic en;
    logic vld_reg [NSTG];
    logic signed [IN_W-1:0] v_in [3];
    logic signed [IN_W-1:0] n_in [3];

    // stage registers
    logic signed [31:0]    vn1_reg [3];
    logic signed [IN_W-1:0] v1_reg [3], v2_reg [3], v3_reg [3];
    logic signed [IN_W-1:0] n1_reg [3], n2_reg [3], n3_reg [3], n4_reg [3];
    logic signed [IN_W-1:0] n5_reg [3], n6_reg [3], n7_reg [3];
    logic [IN_W-1:0]       eta1_reg, eta2_reg, eta3_reg, eta4_reg;
    logic signed [33:0]    c2_reg;
    logic signed [49:0]    cn3_reg [3];
    logic signed [49:0]    t4_reg [3];
    logic signed [63:0]    prod5_reg [3];
    logic signed [P_W-1:0] p6_reg [3], p7_reg [3];
    logic [57:0]           sq7_reg [3];

    // square root pipeline, index 0 is loaded from the squared length
    logic [RAD_W-1:0]      rem_reg  [SQRT_BITS+1];
    logic [SQRT_BITS-1:0]  root_reg [SQRT_BITS+1];
    logic signed [P_W-1:0] sp_reg   [SQRT_BITS+1][3];
    logic signed [IN_W-1:0] sn_reg  [SQRT_BITS+1][3];

    logic signed [46:0]    sn_prod_reg [3];
    logic signed [46:0]    ps_reg [3];

    logic signed [OUT_W-1:0] out_reg [3];
    logic                    sat_reg;

    // combinational next values
    logic signed [33:0]    dot_next, c_next;
    logic signed [66:0]    prod_full [3];
    logic signed [64:0]    pr_round [3];
    logic [59:0]           len2_next;
    logic signed [60:0]    diff_next;
    logic signed [47:0]    sum_next [3];
    logic signed [27:0]    r_next [3];
    logic signed [OUT_W-1:0] out_next [3];
    logic                    sat_next;

    assign v_in[0] = dir_x;
    assign v_in[1] = dir_y;
    assign v_in[2] = dir_z;
    assign n_in[0] = norm_x;
    assign n_in[1] = norm_y;
    assign n_in[2] = norm_z;

    // whole pipe advances unless the last beat is held
    assign en       = !vld_reg[NSTG-1] || out_ready;
    assign in_ready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // cosine: negated dot product, capped at one
    always_comb
    begin
        dot_next = 34'(vn1_reg[0]) + 34'(vn1_reg[1]) + 34'(vn1_reg[2]);
        c_next   = -dot_next;
        if (c_next > 34'sd268435456)
            c_next = 34'sd268435456;
    end

    // perpendicular part rounding and squared length
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_full[i] = t4_reg[i] * $signed({1'b0, eta4_reg});
            pr_round[i]  = 65'(prod5_reg[i]) + (65'sd1 <<< 34);
        end
        len2_next = 60'(sq7_reg[0]) + 60'(sq7_reg[1]) + 60'(sq7_reg[2]);
        diff_next = (61'sd1 <<< 40) - $signed({1'b0, len2_next});
    end

    // final sum, rounding and saturation
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = 48'(ps_reg[i]) - 48'(sn_prod_reg[i]) + (48'sd1 <<< 19);
            r_next[i]   = 28'(sum_next[i] >>> 20);
            if (r_next[i] > 28'(OUT_MAX))
            begin
                out_next[i] = OUT_MAX;
                sat_next    = 1'b1;
            end
            else if (r_next[i] < 28'(OUT_MIN))
            begin
                out_next[i] = OUT_MIN;
                sat_next    = 1'b1;
            end
            else
            begin
                out_next[i] = OUT_W'(r_next[i]);
            end
        end
    end

    // front stages: products, cosine, scaling by eta
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vn1_reg[i] <= v_in[i] * n_in[i];
                v1_reg[i]  <= v_in[i];
                n1_reg[i]  <= n_in[i];
                v2_reg[i]  <= v1_reg[i];
                n2_reg[i]  <= n1_reg[i];
                cn3_reg[i] <= c2_reg * n2_reg[i];
                v3_reg[i]  <= v2_reg[i];
                n3_reg[i]  <= n2_reg[i];
                t4_reg[i]  <= (50'(v3_reg[i]) <<< 28) + cn3_reg[i];
                n4_reg[i]  <= n3_reg[i];
                prod5_reg[i] <= 64'(prod_full[i]);
                n5_reg[i]  <= n4_reg[i];
                p6_reg[i]  <= P_W'(pr_round[i] >>> 35);
                n6_reg[i]  <= n5_reg[i];
                sq7_reg[i] <= 58'(p6_reg[i]) * 58'(p6_reg[i]);
                p7_reg[i]  <= p6_reg[i];
                n7_reg[i]  <= n6_reg[i];
                sp_reg[0][i] <= p7_reg[i];
                sn_reg[0][i] <= n7_reg[i];
            end
            eta1_reg <= eta_ratio;
            eta2_reg <= eta1_reg;
            eta3_reg <= eta2_reg;
            eta4_reg <= eta3_reg;
            c2_reg   <= c_next;
            rem_reg[0]  <= diff_next[60] ? RAD_W'(-diff_next) : RAD_W'(diff_next);
            root_reg[0] <= '0;
        end
    end

    // one root bit per stage, remainder tracks radicand minus root squared
    for (genvar j = 0; j < SQRT_BITS; j++)
    begin : g_sqrt
        localparam int K = SQRT_BITS - 1 - j;
        logic [RAD_W:0] trial;
        logic [RAD_W:0] rem_ext;

        always_comb
        begin
            trial   = ((RAD_W+1)'(root_reg[j]) << (K + 1)) + ((RAD_W+1)'(1) << (2 * K));
            rem_ext = {1'b0, rem_reg[j]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_ext >= trial)
                begin
                    rem_reg[j+1]  <= RAD_W'(rem_ext - trial);
                    root_reg[j+1] <= root_reg[j] | (SQRT_BITS'(1) << K);
                end
                else
                begin
                    rem_reg[j+1]  <= rem_reg[j];
                    root_reg[j+1] <= root_reg[j];
                end
                for (int i = 0; i < 3; i++)
                begin
                    sp_reg[j+1][i] <= sp_reg[j][i];
                    sn_reg[j+1][i] <= sn_reg[j][i];
                end
            end
        end
    end

    // back stages: scale normal by root, then round into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sn_prod_reg[i] <= 47'($signed({1'b0, root_reg[SQRT_BITS]}))
                                  * 47'(sn_reg[SQRT_BITS][i]);
                ps_reg[i]      <= 47'(sp_reg[SQRT_BITS][i]) <<< 14;
                out_reg[i]     <= out_next[i];
            end
            sat_reg <= sat_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign saturated = sat_reg;

endmodule

### rtl/vrd_checker.sv
// port-level checks for the refraction pipeline, bound to the top level
`include "vector_refraction_direction_assert.svh"

module vrd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [vrd_pkg::OUT_W-1:0]   out_x,
    input logic signed [vrd_pkg::OUT_W-1:0]   out_y,
    input logic signed [vrd_pkg::OUT_W-1:0]   out_z,
    input logic                               saturated
);
    import vrd_pkg::*;

    // pipe only stalls when a finished beat is waiting
    `VRD_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
    // stall propagates back to the input
    `VRD_ASSERT(a_stall_blocks_input, (out_valid && !out_ready) |-> !in_ready)
    // a clipped beat shows at least one component at a bound
    `VRD_ASSERT(a_sat_at_bound, (out_valid && saturated) |->
        (out_x == OUT_MAX || out_x == OUT_MIN || out_y == OUT_MAX ||
         out_y == OUT_MIN || out_z == OUT_MAX || out_z == OUT_MIN))
    // a held result stays offered
    `VRD_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)

endmodule

bind vector_refraction_direction vrd_checker u_vrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
);
